/* hdl/round_blob_filter_nearest_center_defines.svh */
`ifndef ROUND_BLOB_FILTER_NEAREST_CENTER_DEFINES_SVH
`define ROUND_BLOB_FILTER_NEAREST_CENTER_DEFINES_SVH

// same-cycle implication
`define RBFNC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rbfnc: same-cycle check failed");

// next-cycle implication
`define RBFNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rbfnc: next-cycle check failed");

`endif

/* hdl/rbfnc_pkg.sv */
`default_nettype none

package rbfnc_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int DIST_LIMIT_SQ_DEF = 230400;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int COLOR_W     = 8;
    localparam int SIZE_W      = 24;
    localparam int EXT_W       = 12;
    localparam int OFF_W       = EXT_W - 1;
    localparam int OUT_COORD_W = 12;
    localparam int OUT_OFS_W   = 13;
    localparam int BOX_W       = 13;
    localparam int SUM_W       = 13;
    localparam int TOL_W       = 9;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PI_W        = 26;
    localparam int AREA_SHIFT  = 28;
    localparam int AREA_W      = 24;

    localparam logic [RECIP_W-1:0] TOL_RECIP = 13'd6554;
    localparam logic [PI_W-1:0]    PI_Q24    = 26'd52707178;

    localparam logic [COLOR_W-1:0] RST_TARGET_COLOR = 8'd255;
    localparam logic [SIZE_W-1:0]  RST_MIN_PIXELS   = 24'd20;
    localparam logic [SIZE_W-1:0]  RST_MAX_PIXELS   = 24'd20000;
    localparam logic [EXT_W-1:0]   RST_MIN_EXTENT   = 12'd5;
    localparam logic [EXT_W-1:0]   RST_MAX_EXTENT   = 12'd100;
    localparam logic [EXT_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
    localparam logic [EXT_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
    localparam logic [EXT_W-1:0]   RST_MASK_SIDE    = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_COLOR = 3'd0,
        REG_MIN_PIXELS   = 3'd1,
        REG_MAX_PIXELS   = 3'd2,
        REG_MIN_EXTENT   = 3'd3,
        REG_MAX_EXTENT   = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6,
        REG_MASK_SIDE    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic check;
        logic square;
        logic area;
        logic dist_x;
        logic dist_y;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/rbfnc_ctrl.sv */
`default_nettype none
`include "round_blob_filter_nearest_center_defines.svh"

module rbfnc_ctrl
    import rbfnc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_kind,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SQUARE,
        S_AREA,
        S_DIST_X,
        S_DIST_Y,
        S_DECIDE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   stall;
    logic   accept;

    always_comb begin
        stall  = (r_state != S_IDLE) || (i_kind && i_sts.out_full && i_out_stall);
        accept = i_in_valid && !stall;

        o_cmd        = '0;
        o_cmd.load   = accept && !i_kind;
        o_cmd.emit   = accept && i_kind;
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.square = (r_state == S_SQUARE);
        o_cmd.area   = (r_state == S_AREA);
        o_cmd.dist_x = (r_state == S_DIST_X);
        o_cmd.dist_y = (r_state == S_DIST_Y);
        o_cmd.decide = (r_state == S_DECIDE);

        case (r_state)
            S_IDLE:   n_state = (accept && !i_kind) ? S_CHECK : S_IDLE;
            S_CHECK:  n_state = S_SQUARE;
            S_SQUARE: n_state = S_AREA;
            S_AREA:   n_state = S_DIST_X;
            S_DIST_X: n_state = S_DIST_Y;
            S_DIST_Y: n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RBFNC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.emit, !(i_sts.out_full && i_out_stall))
    `RBFNC_ASSERT_NEXT(a_blob_starts, i_clk, i_rst_n, o_cmd.load, r_state == S_CHECK)
    `RBFNC_ASSERT_NEXT(a_decide_ends, i_clk, i_rst_n, r_state == S_DECIDE, r_state == S_IDLE)

endmodule

`default_nettype wire

/* hdl/rbfnc_dp.sv */
`default_nettype none

module rbfnc_dp
    import rbfnc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIST_LIMIT_SQ = DIST_LIMIT_SQ_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    output t_sts                               o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  wire logic [COLOR_W-1:0]            i_blob_color,
    input  wire logic [SIZE_W-1:0]             i_blob_size,
    input  wire logic [COORD_BITS-1:0]         i_box_left,
    input  wire logic [COORD_BITS-1:0]         i_box_right,
    input  wire logic [COORD_BITS-1:0]         i_box_top,
    input  wire logic [COORD_BITS-1:0]         i_box_bottom,
    input  wire logic [COORD_BITS-1:0]         i_centre_x,
    input  wire logic [COORD_BITS-1:0]         i_centre_y,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [OUT_COORD_W-1:0]             o_best_x,
    output logic [OUT_COORD_W-1:0]             o_best_y,
    output logic signed [OUT_OFS_W-1:0]        o_best_dx,
    output logic signed [OUT_OFS_W-1:0]        o_best_dy,
    output logic [SIZE_W-1:0]                  o_best_size,
    output logic [BOX_W-1:0]                   o_best_left,
    output logic [BOX_W-1:0]                   o_best_right,
    output logic [BOX_W-1:0]                   o_best_top,
    output logic [BOX_W-1:0]                   o_best_bottom
);

    localparam int CB  = COORD_BITS;
    localparam int EW  = (CB > EXT_W) ? CB : EXT_W;
    localparam int XW  = EW + 1;
    localparam int SQW = 2 * XW + 2;
    localparam int DW  = SQW + 1;
    localparam int BW  = $clog2(DIST_LIMIT_SQ + 1);
    localparam int TPW = EXT_W + RECIP_W;
    localparam int APW = PI_W + 2 * SUM_W;

    // configuration
    logic [COLOR_W-1:0] r_target_color;
    logic [SIZE_W-1:0]  r_min_px;
    logic [SIZE_W-1:0]  r_max_px;
    logic [EXT_W-1:0]   r_min_ext;
    logic [EXT_W-1:0]   r_max_ext;
    logic [EXT_W-1:0]   r_fw;
    logic [EXT_W-1:0]   r_fh;
    logic [EXT_W-1:0]   r_mask;

    // derived from configuration
    logic [TOL_W-1:0]   r_tol;
    logic [OFF_W-1:0]   r_offx;
    logic [OFF_W-1:0]   r_offy;
    logic [OFF_W-1:0]   r_halfw;
    logic [OFF_W-1:0]   r_halfh;

    // current word
    logic [COLOR_W-1:0] r_color;
    logic [SIZE_W-1:0]  r_size;
    logic [CB-1:0]      r_left;
    logic [CB-1:0]      r_right;
    logic [CB-1:0]      r_top;
    logic [CB-1:0]      r_bottom;
    logic [CB-1:0]      r_cx;
    logic [CB-1:0]      r_cy;

    // working registers
    logic               r_pass;
    logic [SUM_W-1:0]   r_s;
    logic [2*SUM_W-1:0] r_sq;
    logic [AREA_W-1:0]  r_area;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      r_y;
    logic signed [XW:0] r_dx;
    logic signed [XW:0] r_dy;
    logic [SQW-1:0]     r_dx2;
    logic [SQW-1:0]     r_dy2;
    logic [BOX_W-1:0]   r_bl;
    logic [BOX_W-1:0]   r_br;
    logic [BOX_W-1:0]   r_bt;
    logic [BOX_W-1:0]   r_bb;

    // kept blob
    logic               r_have;
    logic [BW-1:0]      r_best;
    logic [SIZE_W-1:0]  r_k_size;
    logic [OUT_COORD_W-1:0] r_k_x;
    logic [OUT_COORD_W-1:0] r_k_y;
    logic [OUT_OFS_W-1:0]   r_k_dx;
    logic [OUT_OFS_W-1:0]   r_k_dy;
    logic [BOX_W-1:0]   r_k_l;
    logic [BOX_W-1:0]   r_k_r;
    logic [BOX_W-1:0]   r_k_t;
    logic [BOX_W-1:0]   r_k_b;

    // result word
    logic               r_out_valid;
    logic               r_o_found;
    logic [OUT_COORD_W-1:0] r_o_x;
    logic [OUT_COORD_W-1:0] r_o_y;
    logic [OUT_OFS_W-1:0]   r_o_dx;
    logic [OUT_OFS_W-1:0]   r_o_dy;
    logic [SIZE_W-1:0]  r_o_size;
    logic [BOX_W-1:0]   r_o_l;
    logic [BOX_W-1:0]   r_o_r;
    logic [BOX_W-1:0]   r_o_t;
    logic [BOX_W-1:0]   r_o_b;

    // combinational
    logic [EXT_W:0]     ext_sum;
    logic [TPW-1:0]     tol_prod;
    logic [EXT_W-1:0]   m1;
    logic [EXT_W-1:0]   m_clamp;
    logic [EXT_W-1:0]   gap_x;
    logic [EXT_W-1:0]   gap_y;
    logic signed [CB:0] w_c;
    logic signed [CB:0] h_c;
    logic [CB-1:0]      w_mag;
    logic [CB-1:0]      h_mag;
    logic               w_ok;
    logic               h_ok;
    logic signed [CB+1:0] wd_c;
    logic [CB+1:0]      absd;
    logic               pass_c;
    logic [CB:0]        s_full;
    logic [XW-1:0]      x_c;
    logic [XW-1:0]      y_c;
    logic [XW-1:0]      bl_c;
    logic [XW-1:0]      br_c;
    logic [XW-1:0]      bt_c;
    logic [XW-1:0]      bb_c;
    logic signed [XW:0] dx_c;
    logic signed [XW:0] dy_c;
    logic [APW-1:0]     area_prod;
    logic [AREA_W-1:0]  area_diff;
    logic signed [SQW-1:0] dx2_c;
    logic signed [SQW-1:0] dy2_c;
    logic [DW-1:0]      d_c;
    logic               better;

    always_comb begin
        ext_sum  = {1'b0, r_max_ext} + {1'b0, r_min_ext};
        tol_prod = TPW'(ext_sum[EXT_W:1]) * TPW'(TOL_RECIP);
        m1       = (r_mask > r_fw) ? r_fw : r_mask;
        m_clamp  = (m1 > r_fh) ? r_fh : m1;
        gap_x    = r_fw - m_clamp;
        gap_y    = r_fh - m_clamp;

        w_c   = signed'({1'b0, r_right}) - signed'({1'b0, r_left});
        h_c   = signed'({1'b0, r_bottom}) - signed'({1'b0, r_top});
        w_mag = w_c[CB-1:0];
        h_mag = h_c[CB-1:0];
        w_ok  = !w_c[CB] && (EW'(w_mag) >= EW'(r_min_ext)) && (EW'(w_mag) <= EW'(r_max_ext));
        h_ok  = !h_c[CB] && (EW'(h_mag) >= EW'(r_min_ext)) && (EW'(h_mag) <= EW'(r_max_ext));
        wd_c  = (CB+2)'(w_c) - (CB+2)'(h_c);
        absd  = wd_c[CB+1] ? unsigned'(-wd_c) : unsigned'(wd_c);
        pass_c = (r_color == r_target_color) && (r_size >= r_min_px) &&
                 (r_size <= r_max_px) && w_ok && h_ok && (absd <= (CB+2)'(r_tol));
        s_full = {1'b0, w_mag} + {1'b0, h_mag};

        x_c  = XW'(r_cx) + XW'(r_offx);
        y_c  = XW'(r_cy) + XW'(r_offy);
        bl_c = XW'(r_left) + XW'(r_offx);
        br_c = XW'(r_right) + XW'(r_offx);
        bt_c = XW'(r_top) + XW'(r_offy);
        bb_c = XW'(r_bottom) + XW'(r_offy);
        dx_c = signed'({1'b0, x_c}) - signed'((XW+1)'(r_halfw));
        dy_c = signed'({1'b0, y_c}) - signed'((XW+1)'(r_halfh));

        area_prod = APW'(PI_Q24) * APW'(r_sq);
        area_diff = (r_area >= r_size) ? (r_area - r_size) : (r_size - r_area);

        dx2_c = r_dx * r_dx;
        dy2_c = r_dy * r_dy;

        d_c    = DW'(r_dx2) + DW'(r_dy2);
        better = r_pass && ((d_c < DW'(r_best)) ||
                 (r_have && (d_c == DW'(r_best)) && (r_size > r_k_size)));
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_color <= RST_TARGET_COLOR;
            r_min_px       <= RST_MIN_PIXELS;
            r_max_px       <= RST_MAX_PIXELS;
            r_min_ext      <= RST_MIN_EXTENT;
            r_max_ext      <= RST_MAX_EXTENT;
            r_fw           <= RST_FRAME_WIDTH;
            r_fh           <= RST_FRAME_HEIGHT;
            r_mask         <= RST_MASK_SIDE;
            r_have         <= 1'b0;
            r_best         <= BW'(DIST_LIMIT_SQ);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_TARGET_COLOR: r_target_color <= i_cfg_data[COLOR_W-1:0];
                    REG_MIN_PIXELS:   r_min_px       <= i_cfg_data[SIZE_W-1:0];
                    REG_MAX_PIXELS:   r_max_px       <= i_cfg_data[SIZE_W-1:0];
                    REG_MIN_EXTENT:   r_min_ext      <= i_cfg_data[EXT_W-1:0];
                    REG_MAX_EXTENT:   r_max_ext      <= i_cfg_data[EXT_W-1:0];
                    REG_FRAME_WIDTH:  r_fw           <= i_cfg_data[EXT_W-1:0];
                    REG_FRAME_HEIGHT: r_fh           <= i_cfg_data[EXT_W-1:0];
                    REG_MASK_SIDE:    r_mask         <= i_cfg_data[EXT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_have <= 1'b0;
                r_best <= BW'(DIST_LIMIT_SQ);
            end else if (i_cmd.decide && better) begin
                r_have <= 1'b1;
                r_best <= d_c[BW-1:0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_tol   <= tol_prod[RECIP_SHIFT +: TOL_W];
        r_offx  <= gap_x[EXT_W-1:1];
        r_offy  <= gap_y[EXT_W-1:1];
        r_halfw <= r_fw[EXT_W-1:1];
        r_halfh <= r_fh[EXT_W-1:1];

        if (i_cmd.load) begin
            r_color  <= i_blob_color;
            r_size   <= i_blob_size;
            r_left   <= i_box_left;
            r_right  <= i_box_right;
            r_top    <= i_box_top;
            r_bottom <= i_box_bottom;
            r_cx     <= i_centre_x;
            r_cy     <= i_centre_y;
        end
        if (i_cmd.check) begin
            r_pass <= pass_c;
            r_s    <= SUM_W'(s_full);
            r_x    <= x_c;
            r_y    <= y_c;
            r_dx   <= dx_c;
            r_dy   <= dy_c;
            r_bl   <= bl_c[BOX_W-1:0];
            r_br   <= br_c[BOX_W-1:0];
            r_bt   <= bt_c[BOX_W-1:0];
            r_bb   <= bb_c[BOX_W-1:0];
        end
        if (i_cmd.square) begin
            r_sq <= r_s * r_s;
        end
        if (i_cmd.area) begin
            r_area <= area_prod[AREA_SHIFT +: AREA_W];
        end
        if (i_cmd.dist_x) begin
            r_dx2  <= unsigned'(dx2_c);
            r_pass <= r_pass && (area_diff <= {2'b00, r_area[AREA_W-1:2]});
        end
        if (i_cmd.dist_y) begin
            r_dy2 <= unsigned'(dy2_c);
        end
        if (i_cmd.decide && better) begin
            r_k_size <= r_size;
            r_k_x    <= r_x[OUT_COORD_W-1:0];
            r_k_y    <= r_y[OUT_COORD_W-1:0];
            r_k_dx   <= r_dx[OUT_OFS_W-1:0];
            r_k_dy   <= r_dy[OUT_OFS_W-1:0];
            r_k_l    <= r_bl;
            r_k_r    <= r_br;
            r_k_t    <= r_bt;
            r_k_b    <= r_bb;
        end
        if (i_cmd.emit) begin
            r_o_found <= r_have;
            r_o_x     <= r_have ? r_k_x : '0;
            r_o_y     <= r_have ? r_k_y : '0;
            r_o_dx    <= r_have ? r_k_dx : '0;
            r_o_dy    <= r_have ? r_k_dy : '0;
            r_o_size  <= r_have ? r_k_size : '0;
            r_o_l     <= r_have ? r_k_l : '0;
            r_o_r     <= r_have ? r_k_r : '0;
            r_o_t     <= r_have ? r_k_t : '0;
            r_o_b     <= r_have ? r_k_b : '0;
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_best_x       = r_o_x;
    assign o_best_y       = r_o_y;
    assign o_best_dx      = signed'(r_o_dx);
    assign o_best_dy      = signed'(r_o_dy);
    assign o_best_size    = r_o_size;
    assign o_best_left    = r_o_l;
    assign o_best_right   = r_o_r;
    assign o_best_top     = r_o_t;
    assign o_best_bottom  = r_o_b;

endmodule

`default_nettype wire

/* hdl/round_blob_filter_nearest_center.sv */
// Channel  Word                    Handshake
// in       blob or end of frame    i_in_valid / o_in_stall
// out      kept blob of the frame  o_out_valid / i_out_stall
// cfg      register write          i_cfg_we, i_cfg_idx, i_cfg_data
//
// A blob word is accepted, then runs six steps through the shared datapath (checks, sum
// square, circle area, dx square, dy square, compare), each square and the area with its
// own multiplier. An end-of-frame word loads the result register; it is held off while a
// blob is in progress or an earlier result is stalled. Blob words pass a stalled result.
// Reset is synchronous: registers return to their reset values, the kept blob is dropped.
`default_nettype none

module round_blob_filter_nearest_center
    import rbfnc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIST_LIMIT_SQ = DIST_LIMIT_SQ_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_kind,
    input  wire logic [COLOR_W-1:0]     i_blob_color,
    input  wire logic [SIZE_W-1:0]      i_blob_size,
    input  wire logic [COORD_BITS-1:0]  i_box_left,
    input  wire logic [COORD_BITS-1:0]  i_box_right,
    input  wire logic [COORD_BITS-1:0]  i_box_top,
    input  wire logic [COORD_BITS-1:0]  i_box_bottom,
    input  wire logic [COORD_BITS-1:0]  i_centre_x,
    input  wire logic [COORD_BITS-1:0]  i_centre_y,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_found,
    output logic [OUT_COORD_W-1:0]      o_best_x,
    output logic [OUT_COORD_W-1:0]      o_best_y,
    output logic signed [OUT_OFS_W-1:0] o_best_dx,
    output logic signed [OUT_OFS_W-1:0] o_best_dy,
    output logic [SIZE_W-1:0]           o_best_size,
    output logic [BOX_W-1:0]            o_best_left,
    output logic [BOX_W-1:0]            o_best_right,
    output logic [BOX_W-1:0]            o_best_top,
    output logic [BOX_W-1:0]            o_best_bottom
);

    t_cmd cmd;
    t_sts sts;

    rbfnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    rbfnc_dp #(
        .COORD_BITS    (COORD_BITS),
        .DIST_LIMIT_SQ (DIST_LIMIT_SQ)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_blob_color  (i_blob_color),
        .i_blob_size   (i_blob_size),
        .i_box_left    (i_box_left),
        .i_box_right   (i_box_right),
        .i_box_top     (i_box_top),
        .i_box_bottom  (i_box_bottom),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_best_x      (o_best_x),
        .o_best_y      (o_best_y),
        .o_best_dx     (o_best_dx),
        .o_best_dy     (o_best_dy),
        .o_best_size   (o_best_size),
        .o_best_left   (o_best_left),
        .o_best_right  (o_best_right),
        .o_best_top    (o_best_top),
        .o_best_bottom (o_best_bottom)
    );

endmodule

`default_nettype wire
